// ----- hw/rtl/diff_drive_pwm_mixer_top_macros.svh -----
// assertion macros for the mixer
`ifndef DIFF_DRIVE_PWM_MIXER_TOP_MACROS_SVH
`define DIFF_DRIVE_PWM_MIXER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle property, off during reset
`define DDPM_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// antecedent this cycle, consequent next cycle
`define DDPM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define DDPM_ASSERT(label, clk, rst_n, prop, msg)
`define DDPM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- hw/rtl/ddpm_pkg.sv -----
`default_nettype none

package ddpm_pkg;

  typedef enum logic [2:0] {
    CMD_DIFF      = 3'd0,
    CMD_CORE_DIFF = 3'd1,
    CMD_TURN      = 3'd2,
    CMD_STOP      = 3'd3,
    CMD_BRAKE     = 3'd4,
    CMD_ENABLE    = 3'd5,
    CMD_DISABLE   = 3'd6
  } cmd_t;

  localparam logic [2:0] CFG_DEADZONE      = 3'd0;
  localparam logic [2:0] CFG_DRIVE_LIMIT   = 3'd1;
  localparam logic [2:0] CFG_PWM_PERIOD    = 3'd2;
  localparam logic [2:0] CFG_BRAKE_DUTY    = 3'd3;
  localparam logic [2:0] CFG_LEFT_REVERSE  = 3'd4;
  localparam logic [2:0] CFG_RIGHT_REVERSE = 3'd5;

  localparam logic [14:0] DEADZONE_RST    = 15'd0;
  localparam logic [14:0] DRIVE_LIMIT_RST = 15'd1000;
  localparam logic [14:0] PWM_PERIOD_RST  = 15'd1000;
  localparam logic [14:0] BRAKE_DUTY_RST  = 15'd0;

  // bridge pin pairs, bit 0 fwd, bit 1 rev
  localparam logic [1:0] PINS_OFF   = 2'b00;
  localparam logic [1:0] PINS_FWD   = 2'b01;
  localparam logic [1:0] PINS_REV   = 2'b10;
  localparam logic [1:0] PINS_BRAKE = 2'b11;

  typedef struct packed {
    logic [14:0] deadzone;
    logic [14:0] drive_limit;
    logic [14:0] pwm_period;
    logic [14:0] brake_duty;
    logic        left_reverse;
    logic        right_reverse;
  } cfg_t;

  typedef struct packed {
    logic               standby;
    logic [1:0]         left_pins;
    logic [1:0]         right_pins;
    logic [14:0]        left_duty;
    logic [14:0]        right_duty;
    logic signed [15:0] applied_left;
    logic signed [15:0] applied_right;
  } state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ddpm_mix.sv -----
`default_nettype none

module ddpm_mix (
  input  wire ddpm_pkg::cmd_t     cmd,
  input  wire logic signed [15:0] first_value,
  input  wire logic signed [15:0] second_value,
  input  wire ddpm_pkg::cfg_t     cfg,
  output logic signed [15:0]      left_cmd,
  output logic signed [15:0]      right_cmd
);

  function automatic logic signed [17:0] lift(input logic signed [17:0] v,
                                              input logic [14:0] dz);
    logic signed [17:0] dzx;
    dzx = signed'({3'b000, dz});
    if (v > 18'sd0 && v < dzx) begin
      lift = dzx;
    end else if (v < 18'sd0 && v > -dzx) begin
      lift = -dzx;
    end else begin
      lift = v;
    end
  endfunction

  function automatic logic signed [17:0] clamp_lim(input logic signed [17:0] v,
                                                   input logic [14:0] lim);
    logic signed [17:0] limx;
    limx = signed'({3'b000, lim});
    if (v > limx) begin
      clamp_lim = limx;
    end else if (v < -limx) begin
      clamp_lim = -limx;
    end else begin
      clamp_lim = v;
    end
  endfunction

  logic signed [17:0] a_x;
  logic signed [17:0] b_x;
  logic signed [17:0] base;
  logic signed [17:0] sum_l;
  logic signed [17:0] sum_r;
  logic signed [17:0] l_x;
  logic signed [17:0] r_x;

  always_comb begin
    a_x   = signed'({{2{first_value[15]}}, first_value});
    b_x   = signed'({{2{second_value[15]}}, second_value});
    base  = lift(a_x, cfg.deadzone);
    sum_l = base + b_x;
    sum_r = base - b_x;
    l_x   = 18'sd0;
    r_x   = 18'sd0;
    unique case (cmd)
      ddpm_pkg::CMD_DIFF: begin
        l_x = base;
        r_x = lift(b_x, cfg.deadzone);
        if (l_x < 18'sd0) l_x = 18'sd0;
        if (r_x < 18'sd0) r_x = 18'sd0;
      end
      ddpm_pkg::CMD_CORE_DIFF: begin
        l_x = sum_l;
        r_x = sum_r;
        // keep both sides on the side of the core speed
        if (a_x > 18'sd0) begin
          if (l_x < 18'sd0) l_x = 18'sd0;
          if (r_x < 18'sd0) r_x = 18'sd0;
        end else if (a_x < 18'sd0) begin
          if (l_x > 18'sd0) l_x = 18'sd0;
          if (r_x > 18'sd0) r_x = 18'sd0;
        end
        l_x = clamp_lim(l_x, cfg.drive_limit);
        r_x = clamp_lim(r_x, cfg.drive_limit);
      end
      ddpm_pkg::CMD_TURN: begin
        l_x = clamp_lim(a_x, cfg.drive_limit);
        r_x = clamp_lim(b_x, cfg.drive_limit);
      end
      default: begin
        l_x = 18'sd0;
        r_x = 18'sd0;
      end
    endcase
  end

  assign left_cmd  = l_x[15:0];
  assign right_cmd = r_x[15:0];

endmodule

`default_nettype wire

// ----- hw/rtl/ddpm_side.sv -----
`default_nettype none

module ddpm_side (
  input  wire logic signed [15:0] side_cmd,
  input  wire logic               reverse,
  input  wire logic [14:0]        pwm_period,
  output logic [1:0]              pins,
  output logic [14:0]             duty
);

  logic signed [16:0] cmd_x;
  logic signed [16:0] s;
  logic [16:0]        mag;

  always_comb begin
    cmd_x = signed'({side_cmd[15], side_cmd});
    s     = reverse ? -cmd_x : cmd_x;
    if (s >= 17'sd0) begin
      pins = ddpm_pkg::PINS_FWD;
      mag  = unsigned'(s);
    end else begin
      pins = ddpm_pkg::PINS_REV;
      mag  = unsigned'(-s);
    end
    if (mag > {2'b00, pwm_period}) begin
      duty = pwm_period;
    end else begin
      duty = mag[14:0];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/diff_drive_pwm_mixer_top.sv -----
// an accepted item is registered in the input stage, and its result is loaded into the held
//   outputs once no result is held or the held one is taken; throughput: one item per cycle
//   while out_stall is low, set by the single mix and drive pass between the two registers
// reset (rst_n low, synchronous): config back to its defaults, standby flag clear, pins off,
//   duties and telemetry zero, no item in flight
`default_nettype none

`include "diff_drive_pwm_mixer_top_macros.svh"

module diff_drive_pwm_mixer_top (
  input  wire logic               clk,
  input  wire logic               rst_n,

  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [14:0]        cfg_wdata,

  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [2:0]         in_cmd,
  input  wire logic signed [15:0] in_first_value,
  input  wire logic signed [15:0] in_second_value,

  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_left_fwd_pin,
  output logic                    out_left_rev_pin,
  output logic                    out_right_fwd_pin,
  output logic                    out_right_rev_pin,
  output logic [14:0]             out_left_duty,
  output logic [14:0]             out_right_duty,
  output logic                    out_standby_on,
  output logic signed [15:0]      out_applied_left,
  output logic signed [15:0]      out_applied_right
);

  ddpm_pkg::cfg_t     cfg_r;
  ddpm_pkg::cfg_t     cfg_nxt;

  logic               s1_valid_r;
  logic               s1_valid_nxt;
  logic [2:0]         s1_cmd_r;
  logic signed [15:0] s1_a_r;
  logic signed [15:0] s1_b_r;

  // held outputs double as the result register
  ddpm_pkg::state_t   state_r;
  ddpm_pkg::state_t   state_nxt;
  logic               out_valid_r;
  logic               out_valid_nxt;

  logic               in_acc;
  logic               adv;
  ddpm_pkg::cmd_t     cmd;
  logic signed [15:0] left_cmd;
  logic signed [15:0] right_cmd;
  logic [1:0]         left_pins;
  logic [1:0]         right_pins;
  logic [14:0]        left_duty;
  logic [14:0]        right_duty;
  logic [14:0]        brake_duty;

  assign adv      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !adv;
  assign in_acc   = in_valid && !in_stall;
  assign cmd      = ddpm_pkg::cmd_t'(s1_cmd_r);

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        ddpm_pkg::CFG_DEADZONE:      cfg_nxt.deadzone      = cfg_wdata;
        ddpm_pkg::CFG_DRIVE_LIMIT:   cfg_nxt.drive_limit   = cfg_wdata;
        ddpm_pkg::CFG_PWM_PERIOD:    cfg_nxt.pwm_period    = cfg_wdata;
        ddpm_pkg::CFG_BRAKE_DUTY:    cfg_nxt.brake_duty    = cfg_wdata;
        ddpm_pkg::CFG_LEFT_REVERSE:  cfg_nxt.left_reverse  = cfg_wdata[0];
        ddpm_pkg::CFG_RIGHT_REVERSE: cfg_nxt.right_reverse = cfg_wdata[0];
        default:                     cfg_nxt = cfg_r;
      endcase
    end
  end

  ddpm_mix u_mix (
    .cmd          (cmd),
    .first_value  (s1_a_r),
    .second_value (s1_b_r),
    .cfg          (cfg_r),
    .left_cmd     (left_cmd),
    .right_cmd    (right_cmd)
  );

  ddpm_side u_side_left (
    .side_cmd   (left_cmd),
    .reverse    (cfg_r.left_reverse),
    .pwm_period (cfg_r.pwm_period),
    .pins       (left_pins),
    .duty       (left_duty)
  );

  ddpm_side u_side_right (
    .side_cmd   (right_cmd),
    .reverse    (cfg_r.right_reverse),
    .pwm_period (cfg_r.pwm_period),
    .pins       (right_pins),
    .duty       (right_duty)
  );

  assign brake_duty = (cfg_r.brake_duty > cfg_r.pwm_period) ? cfg_r.pwm_period
                                                             : cfg_r.brake_duty;

  always_comb begin
    state_nxt = state_r;
    unique case (cmd)
      ddpm_pkg::CMD_DIFF, ddpm_pkg::CMD_CORE_DIFF, ddpm_pkg::CMD_TURN: begin
        state_nxt.left_pins     = left_pins;
        state_nxt.right_pins    = right_pins;
        state_nxt.left_duty     = left_duty;
        state_nxt.right_duty    = right_duty;
        state_nxt.applied_left  = left_cmd;
        state_nxt.applied_right = right_cmd;
      end
      ddpm_pkg::CMD_STOP: begin
        state_nxt.left_pins     = ddpm_pkg::PINS_OFF;
        state_nxt.right_pins    = ddpm_pkg::PINS_OFF;
        state_nxt.left_duty     = '0;
        state_nxt.right_duty    = '0;
        state_nxt.applied_left  = '0;
        state_nxt.applied_right = '0;
      end
      ddpm_pkg::CMD_BRAKE: begin
        state_nxt.standby       = 1'b1;
        state_nxt.left_pins     = ddpm_pkg::PINS_BRAKE;
        state_nxt.right_pins    = ddpm_pkg::PINS_BRAKE;
        state_nxt.left_duty     = brake_duty;
        state_nxt.right_duty    = brake_duty;
        state_nxt.applied_left  = '0;
        state_nxt.applied_right = '0;
      end
      ddpm_pkg::CMD_ENABLE:  state_nxt.standby = 1'b1;
      ddpm_pkg::CMD_DISABLE: state_nxt.standby = 1'b0;
      // unused code leaves everything held
      default: state_nxt = state_r;
    endcase
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.deadzone      <= ddpm_pkg::DEADZONE_RST;
      cfg_r.drive_limit   <= ddpm_pkg::DRIVE_LIMIT_RST;
      cfg_r.pwm_period    <= ddpm_pkg::PWM_PERIOD_RST;
      cfg_r.brake_duty    <= ddpm_pkg::BRAKE_DUTY_RST;
      cfg_r.left_reverse  <= 1'b0;
      cfg_r.right_reverse <= 1'b0;
      s1_valid_r          <= 1'b0;
      out_valid_r         <= 1'b0;
      state_r             <= '0;
    end else begin
      cfg_r       <= cfg_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (adv) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd_r <= in_cmd;
      s1_a_r   <= in_first_value;
      s1_b_r   <= in_second_value;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_left_fwd_pin  = state_r.left_pins[0];
  assign out_left_rev_pin  = state_r.left_pins[1];
  assign out_right_fwd_pin = state_r.right_pins[0];
  assign out_right_rev_pin = state_r.right_pins[1];
  assign out_left_duty     = state_r.left_duty;
  assign out_right_duty    = state_r.right_duty;
  assign out_standby_on    = state_r.standby;
  assign out_applied_left  = state_r.applied_left;
  assign out_applied_right = state_r.applied_right;

  `DDPM_ASSERT(a_result_has_source, clk, rst_n,
    $rose(out_valid_r) |-> $past(s1_valid_r),
    "result appeared without an item in the input register")
  `DDPM_ASSERT_NEXT(a_accept_fills_stage, clk, rst_n, in_acc, s1_valid_r,
    "accepted item not held in the input register")
  `DDPM_ASSERT(a_off_pins_zero_duty, clk, rst_n,
    (state_r.left_pins == ddpm_pkg::PINS_OFF) |->
      (state_r.left_duty == 15'd0 && state_r.applied_left == 16'sd0),
    "left side off with nonzero duty or telemetry")
  `DDPM_ASSERT(a_brake_zero_telemetry, clk, rst_n,
    (state_r.right_pins == ddpm_pkg::PINS_BRAKE) |->
      (state_r.applied_right == 16'sd0 && state_r.left_pins == ddpm_pkg::PINS_BRAKE),
    "brake pins without matching telemetry")

endmodule

`default_nettype wire

// ----- tb/tb_diff_drive_pwm_mixer_top.sv -----
`timescale 1ns / 1ps

module tb_diff_drive_pwm_mixer_top;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS_PER_PHASE = 540;
  localparam int ITEMS_PER_SETTING = 90;

  // command code outside the defined set, and register indexes with no register behind them
  localparam logic [2:0] CMD_UNUSED = 3'd7;
  localparam logic [2:0] CFG_SPARE_LO = 3'd6;
  localparam logic [2:0] CFG_SPARE_HI = 3'd7;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [14:0] cfg_wdata;
  logic in_valid;
  logic in_stall;
  logic [2:0] in_cmd;
  logic signed [15:0] in_first_value;
  logic signed [15:0] in_second_value;
  logic out_valid;
  logic out_stall;
  logic out_left_fwd_pin;
  logic out_left_rev_pin;
  logic out_right_fwd_pin;
  logic out_right_rev_pin;
  logic [14:0] out_left_duty;
  logic [14:0] out_right_duty;
  logic out_standby_on;
  logic signed [15:0] out_applied_left;
  logic signed [15:0] out_applied_right;

  ddpm_pkg::cfg_t shadow_cfg;
  ddpm_pkg::state_t mixer_state;
  ddpm_pkg::state_t pending_outputs[$];

  int send_idle_pct;
  int stall_pct;
  int error_count;
  int items_sent;
  int results_checked;
  int config_sets;
  int cycle_count;

  diff_drive_pwm_mixer_top i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_cmd            (in_cmd),
    .in_first_value    (in_first_value),
    .in_second_value   (in_second_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_left_fwd_pin  (out_left_fwd_pin),
    .out_left_rev_pin  (out_left_rev_pin),
    .out_right_fwd_pin (out_right_fwd_pin),
    .out_right_rev_pin (out_right_rev_pin),
    .out_left_duty     (out_left_duty),
    .out_right_duty    (out_right_duty),
    .out_standby_on    (out_standby_on),
    .out_applied_left  (out_applied_left),
    .out_applied_right (out_applied_right)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int lift_dz(int v);
    int dz;
    dz = int'(shadow_cfg.deadzone);
    if (v > 0 && v < dz) return dz;
    if (v < 0 && v > -dz) return -dz;
    return v;
  endfunction

  function automatic int clamp_lim(int v);
    int lim;
    lim = int'(shadow_cfg.drive_limit);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic void drive_side(int side_cmd, logic rev, output logic [1:0] pins,
                                     output logic [14:0] duty);
    int s;
    int mag;
    s = rev ? -side_cmd : side_cmd;
    if (s >= 0) begin
      pins = ddpm_pkg::PINS_FWD;
      mag = s;
    end else begin
      pins = ddpm_pkg::PINS_REV;
      mag = -s;
    end
    if (mag > int'(shadow_cfg.pwm_period)) mag = int'(shadow_cfg.pwm_period);
    duty = mag[14:0];
  endfunction

  function automatic ddpm_pkg::state_t mix_and_drive(logic [2:0] code,
                                                     logic signed [15:0] first_val,
                                                     logic signed [15:0] second_val);
    int a;
    int b;
    int l;
    int r;
    int base;
    logic [14:0] brake_d;
    logic drive;
    a = first_val;
    b = second_val;
    l = 0;
    r = 0;
    drive = 1'b0;
    case (code)
      ddpm_pkg::CMD_DIFF: begin
        l = lift_dz(a);
        r = lift_dz(b);
        if (l < 0) l = 0;
        if (r < 0) r = 0;
        drive = 1'b1;
      end
      ddpm_pkg::CMD_CORE_DIFF: begin
        // sums at full width, no 16-bit wrap before the clamp
        base = lift_dz(a);
        l = base + b;
        r = base - b;
        if (a > 0) begin
          if (l < 0) l = 0;
          if (r < 0) r = 0;
        end else if (a < 0) begin
          if (l > 0) l = 0;
          if (r > 0) r = 0;
        end
        l = clamp_lim(l);
        r = clamp_lim(r);
        drive = 1'b1;
      end
      ddpm_pkg::CMD_TURN: begin
        l = clamp_lim(a);
        r = clamp_lim(b);
        drive = 1'b1;
      end
      ddpm_pkg::CMD_STOP: begin
        mixer_state.left_pins = ddpm_pkg::PINS_OFF;
        mixer_state.right_pins = ddpm_pkg::PINS_OFF;
        mixer_state.left_duty = '0;
        mixer_state.right_duty = '0;
        mixer_state.applied_left = '0;
        mixer_state.applied_right = '0;
      end
      ddpm_pkg::CMD_BRAKE: begin
        brake_d = shadow_cfg.brake_duty;
        if (brake_d > shadow_cfg.pwm_period) brake_d = shadow_cfg.pwm_period;
        mixer_state.standby = 1'b1;
        mixer_state.left_pins = ddpm_pkg::PINS_BRAKE;
        mixer_state.right_pins = ddpm_pkg::PINS_BRAKE;
        mixer_state.left_duty = brake_d;
        mixer_state.right_duty = brake_d;
        mixer_state.applied_left = '0;
        mixer_state.applied_right = '0;
      end
      ddpm_pkg::CMD_ENABLE: mixer_state.standby = 1'b1;
      ddpm_pkg::CMD_DISABLE: mixer_state.standby = 1'b0;
      default: ;
    endcase
    if (drive) begin
      mixer_state.applied_left = l[15:0];
      mixer_state.applied_right = r[15:0];
      drive_side(l, shadow_cfg.left_reverse, mixer_state.left_pins, mixer_state.left_duty);
      drive_side(r, shadow_cfg.right_reverse, mixer_state.right_pins, mixer_state.right_duty);
    end
    return mixer_state;
  endfunction

  function automatic void apply_cfg_write(logic [2:0] idx, logic [14:0] data);
    case (idx)
      ddpm_pkg::CFG_DEADZONE: shadow_cfg.deadzone = data;
      ddpm_pkg::CFG_DRIVE_LIMIT: shadow_cfg.drive_limit = data;
      ddpm_pkg::CFG_PWM_PERIOD: shadow_cfg.pwm_period = data;
      ddpm_pkg::CFG_BRAKE_DUTY: shadow_cfg.brake_duty = data;
      ddpm_pkg::CFG_LEFT_REVERSE: shadow_cfg.left_reverse = data[0];
      ddpm_pkg::CFG_RIGHT_REVERSE: shadow_cfg.right_reverse = data[0];
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------- monitors

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) apply_cfg_write(cfg_index, cfg_wdata);
      if (in_valid && !in_stall) begin
        pending_outputs.push_back(mix_and_drive(in_cmd, in_first_value, in_second_value));
        items_sent++;
      end
    end
  end

  task automatic report_mismatch(string msg);
    error_count++;
    if (error_count <= 40) $display("mismatch at result %0d: %s", results_checked, msg);
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  always @(posedge clk) begin : check_outputs
    ddpm_pkg::state_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_outputs.size() == 0) begin
        report_mismatch("result with no item outstanding");
      end else begin
        want = pending_outputs.pop_front();
        check_field("left_fwd_pin", 16'(out_left_fwd_pin), 16'(want.left_pins[0]));
        check_field("left_rev_pin", 16'(out_left_rev_pin), 16'(want.left_pins[1]));
        check_field("right_fwd_pin", 16'(out_right_fwd_pin), 16'(want.right_pins[0]));
        check_field("right_rev_pin", 16'(out_right_rev_pin), 16'(want.right_pins[1]));
        check_field("left_duty", 16'(out_left_duty), 16'(want.left_duty));
        check_field("right_duty", 16'(out_right_duty), 16'(want.right_duty));
        check_field("standby_on", 16'(out_standby_on), 16'(want.standby));
        check_field("applied_left", out_applied_left, want.applied_left);
        check_field("applied_right", out_applied_right, want.applied_right);
        results_checked++;
      end
    end
  end

  always @(negedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_outputs.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------- drivers

  task automatic send_cmd(logic [2:0] code, logic signed [15:0] first_val,
                          logic signed [15:0] second_val);
    int gap;
    gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 4) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_cmd <= code;
    in_first_value <= first_val;
    in_second_value <= second_val;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [14:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_config(logic [14:0] dz, logic [14:0] lim, logic [14:0] period,
                              logic [14:0] brake, logic lrev, logic rrev);
    wait_drained();
    write_reg(ddpm_pkg::CFG_DEADZONE, dz);
    write_reg(ddpm_pkg::CFG_DRIVE_LIMIT, lim);
    write_reg(ddpm_pkg::CFG_PWM_PERIOD, period);
    write_reg(ddpm_pkg::CFG_BRAKE_DUTY, brake);
    // upper bits of the direction writes are don't-care
    write_reg(ddpm_pkg::CFG_LEFT_REVERSE, {14'($urandom), lrev});
    write_reg(ddpm_pkg::CFG_RIGHT_REVERSE, {14'($urandom), rrev});
    if ($urandom_range(3) == 0) write_reg(CFG_SPARE_LO, 15'($urandom));
    if ($urandom_range(3) == 0) write_reg(CFG_SPARE_HI, 15'($urandom));
    config_sets++;
  endtask

  function automatic logic [14:0] pick_reg_value();
    case ($urandom_range(5))
      0: return 15'd0;
      1: return 15'h7fff;
      2, 3: return 15'($urandom_range(1, 2000));
      default: return 15'($urandom);
    endcase
  endfunction

  function automatic logic signed [15:0] pick_value();
    case ($urandom_range(9))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return 16'sd0;
      3, 4, 5: return 16'($urandom_range(0, 4000) - 2000);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [2:0] pick_cmd();
    case ($urandom_range(19))
      0, 1, 2, 3, 4: return ddpm_pkg::CMD_DIFF;
      5, 6, 7, 8, 9: return ddpm_pkg::CMD_CORE_DIFF;
      10, 11, 12, 13: return ddpm_pkg::CMD_TURN;
      14: return ddpm_pkg::CMD_STOP;
      15: return ddpm_pkg::CMD_BRAKE;
      16, 19: return ddpm_pkg::CMD_ENABLE;
      17: return ddpm_pkg::CMD_DISABLE;
      default: return CMD_UNUSED;
    endcase
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_reset_defaults();
    send_cmd(ddpm_pkg::CMD_STOP, 16'sd0, 16'sd0);
    send_cmd(ddpm_pkg::CMD_ENABLE, 16'sd0, 16'sd0);
    send_cmd(ddpm_pkg::CMD_DIFF, 16'sd0, 16'sd0);
    send_cmd(ddpm_pkg::CMD_DIFF, 16'sd32767, -16'sd32768);
    send_cmd(ddpm_pkg::CMD_CORE_DIFF, 16'sd0, 16'sd32767);
    send_cmd(ddpm_pkg::CMD_CORE_DIFF, 16'sd32767, 16'sd32767);
    send_cmd(ddpm_pkg::CMD_CORE_DIFF, -16'sd32768, -16'sd32768);
    send_cmd(ddpm_pkg::CMD_TURN, -16'sd32768, 16'sd32767);
    send_cmd(ddpm_pkg::CMD_BRAKE, 16'sd1, -16'sd1);
    send_cmd(ddpm_pkg::CMD_DISABLE, 16'sd0, 16'sd0);
    send_cmd(CMD_UNUSED, -16'sd1, 16'sd1);
  endtask

  task automatic test_special_cases();
    // deadzone lift, sign hold, brake duty above the period, full-range turn clamp
    apply_config(15'd100, 15'h7fff, 15'd400, 15'd700, 1'b0, 1'b0);
    send_cmd(ddpm_pkg::CMD_DIFF, 16'sd50, -16'sd50);
    send_cmd(ddpm_pkg::CMD_DIFF, -16'sd1, 16'sd1);
    send_cmd(ddpm_pkg::CMD_CORE_DIFF, 16'sd10, -16'sd200);
    send_cmd(ddpm_pkg::CMD_CORE_DIFF, -16'sd10, -16'sd200);
    send_cmd(ddpm_pkg::CMD_TURN, -16'sd32768, -16'sd32768);
    send_cmd(ddpm_pkg::CMD_BRAKE, 16'sd0, 16'sd0);
    send_cmd(CMD_UNUSED, 16'sd5, 16'sd5);
    // zero period and zero limit, both sides reversed
    apply_config(15'd0, 15'd0, 15'd0, 15'h7fff, 1'b1, 1'b1);
    send_cmd(ddpm_pkg::CMD_CORE_DIFF, 16'sd500, 16'sd5);
    send_cmd(ddpm_pkg::CMD_DIFF, 16'sd32767, 16'sd1);
    send_cmd(ddpm_pkg::CMD_BRAKE, 16'sd0, 16'sd0);
    apply_config(15'h7fff, 15'd300, 15'h7fff, 15'd123, 1'b1, 1'b0);
    send_cmd(ddpm_pkg::CMD_DIFF, 16'sd1, -16'sd32767);
    send_cmd(ddpm_pkg::CMD_TURN, 16'sd300, -16'sd301);
    send_cmd(ddpm_pkg::CMD_CORE_DIFF, 16'sd0, -16'sd32768);
  endtask

  task automatic test_random_traffic(int sender_idle, int receiver_stall);
    send_idle_pct = sender_idle;
    stall_pct = receiver_stall;
    for (int i = 0; i < RANDOM_ITEMS_PER_PHASE; i++) begin
      if (i % ITEMS_PER_SETTING == 0)
        apply_config(pick_reg_value(), pick_reg_value(), pick_reg_value(), pick_reg_value(),
                     1'($urandom), 1'($urandom));
      send_cmd(pick_cmd(), pick_value(), pick_value());
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_cmd = '0;
    in_first_value = '0;
    in_second_value = '0;
    out_stall = 1'b0;
    send_idle_pct = 0;
    stall_pct = 0;
    error_count = 0;
    items_sent = 0;
    results_checked = 0;
    config_sets = 0;
    cycle_count = 0;
    mixer_state = '0;
    shadow_cfg = '{deadzone: ddpm_pkg::DEADZONE_RST, drive_limit: ddpm_pkg::DRIVE_LIMIT_RST,
                   pwm_period: ddpm_pkg::PWM_PERIOD_RST, brake_duty: ddpm_pkg::BRAKE_DUTY_RST,
                   left_reverse: 1'b0, right_reverse: 1'b0};
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 19;
    stall_pct = 78;
    test_reset_defaults();
    test_special_cases();
    test_random_traffic(19, 78);
    test_random_traffic(78, 19);
    test_random_traffic(0, 0);

    wait_drained();
    repeat (4) @(posedge clk);
    $display("checked %0d results for %0d commands across %0d register settings",
             results_checked, items_sent, config_sets);
    $display("sender and receiver idled in turn, then ran back to back");
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", error_count);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
